/* design/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Action and status codes, sequencer states and the default operand width.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int unsigned DefWidth = 32;

	typedef enum logic [2:0] {
		ACT_NORM = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4,
		ACT_CMP  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_OVFL  = 2'd2,
		ST_SIGN  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ORD_LESS  = 2'd0,
		ORD_EQUAL = 2'd1,
		ORD_GREAT = 2'd2
	} order_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMB,
		S_GCD_K,
		S_GCD_A,
		S_GCD_B,
		S_GCD_SUB,
		S_GCD_SHL,
		S_DIV_Q,
		S_DIV_R,
		S_PACK,
		S_OUT
	} state_t;

endpackage

/* design/rau_if.sv */
// ----------------------------------------------------------------------------
// rau_if: valid/ready channel
// Carries one item per transfer, with source and sink modports.
// ----------------------------------------------------------------------------
interface rau_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: fraction ALU
// Normalize, add, subtract, multiply, divide and compare of two fractions.
// ----------------------------------------------------------------------------
// channel  | role | payload
// in_ch    | sink | action, a_num, a_den, b_num, b_den
// out_ch   | src  | res_num, res_den, order, status
//
// One item at a time. Products use one shared WIDTH x WIDTH multiplier in
// states S_MUL1 to S_MUL3; the binary gcd works on 2*WIDTH-bit values, and
// the two divisions share one divider. Errors and compare skip gcd and division.
// Reset clears the sequencer, the divider control and the output valid only. A
// result waits in the output register until taken; no new item is accepted
// meanwhile.
module rational_arithmetic_unit_top #(
	parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
	input  logic clk,
	input  logic arst_n,
	rau_if.sink   in_ch,
	rau_if.source out_ch
);
	import rau_pkg::*;

	localparam int unsigned W2 = 2 * WIDTH;
	localparam int unsigned KW = $clog2(W2 + 1);

	state_t state_q, state_d;

	logic [2:0]       act_q;
	logic [WIDTH-1:0] anm_q, adm_q, bnm_q, bdm_q;
	logic             an_q, bn_q;
	logic [W2-1:0]    p1_q, p2_q, p3_q;
	logic [W2-1:0]    nm_q, dm_q, ga_q, gb_q, q_q;
	logic             nneg_q, dneg_q;
	logic [KW-1:0]    k_q;
	logic [WIDTH-1:0] rnum_q;
	logic [WIDTH-2:0] rden_q;
	order_t           order_q;
	status_t          status_q;
	logic             ovalid_q;

	// Shared multiplier.
	logic [WIDTH-1:0] mx, my;
	logic [W2-1:0]    prod;
	assign prod = W2'(mx) * W2'(my);

	// Operand magnitudes from the input payload.
	logic [WIDTH-1:0] i_an, i_ad, i_bn, i_bd;
	logic             s_an, s_ad, s_bn, s_bd;
	assign s_an = in_ch.data.a_num[WIDTH-1];
	assign s_ad = in_ch.data.a_den[WIDTH-1];
	assign s_bn = in_ch.data.b_num[WIDTH-1];
	assign s_bd = in_ch.data.b_den[WIDTH-1];
	assign i_an = s_an ? -in_ch.data.a_num : in_ch.data.a_num;
	assign i_ad = s_ad ? -in_ch.data.a_den : in_ch.data.a_den;
	assign i_bn = s_bn ? -in_ch.data.b_num : in_ch.data.b_num;
	assign i_bd = s_bd ? -in_ch.data.b_den : in_ch.data.b_den;

	logic in_xfer, out_xfer, act_ok;
	assign in_ch.ready = (state_q == S_IDLE) && !ovalid_q;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = out_ch.valid && out_ch.ready;
	assign act_ok      = in_ch.data.action <= 3'(ACT_CMP);

	logic       e_zero, e_sign, binary;
	assign binary = in_ch.data.action != 3'(ACT_NORM);
	assign e_zero = (i_ad == '0) || (binary && i_bd == '0) ||
		(in_ch.data.action == 3'(ACT_DIV) && i_bn == '0);
	assign e_sign = binary && (s_ad || s_bd);

	// Divider, shared by both quotients.
	logic          dv_start, dv_done;
	logic [W2-1:0] dv_num, dv_quo;
	rau_div #(.N(W2)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(dv_num), .den(ga_q), .done(dv_done), .quo(dv_quo)
	);

	// Combined numerator for add/sub.
	logic          s2;
	logic [W2-1:0] t_sum, t_d12, t_d21;
	logic          t_ge;
	assign s2    = bn_q ^ (act_q == 3'(ACT_SUB));
	assign t_sum = p1_q + p2_q;
	assign t_d12 = p1_q - p2_q;
	assign t_d21 = p2_q - p1_q;
	assign t_ge  = p1_q >= p2_q;

	// Gcd step.
	logic [W2-1:0] g_lo, g_hi;
	assign g_lo = (ga_q > gb_q) ? gb_q : ga_q;
	assign g_hi = (ga_q > gb_q) ? ga_q : gb_q;

	// Packing of the reduced result.
	logic          neg;
	logic [W2-1:0] maxpos;
	logic          ovf;
	assign neg    = nneg_q ^ dneg_q;
	assign maxpos = W2'({(WIDTH-1){1'b1}});
	assign ovf    = (dv_quo > maxpos) || (q_q > maxpos + W2'(neg));

	always_comb begin
		mx = anm_q;
		my = bdm_q;
		unique case (state_q)
			S_MUL1: begin
				mx = (act_q == 3'(ACT_MUL)) ? anm_q : anm_q;
				my = (act_q == 3'(ACT_MUL)) ? bnm_q : bdm_q;
			end
			S_MUL2: begin
				mx = (act_q == 3'(ACT_DIV)) ? adm_q : bnm_q;
				my = (act_q == 3'(ACT_DIV)) ? bnm_q : adm_q;
			end
			S_MUL3: begin
				mx = adm_q;
				my = bdm_q;
			end
			default: begin
				mx = anm_q;
				my = bdm_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_xfer && act_ok) begin
				if (e_zero || e_sign) state_d = S_OUT;
				else if (in_ch.data.action == 3'(ACT_NORM)) state_d = S_COMB;
				else state_d = S_MUL1;
			end
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = (act_q == 3'(ACT_CMP) || act_q == 3'(ACT_DIV))
				? S_COMB : S_MUL3;
			S_MUL3:   state_d = S_COMB;
			S_COMB:   state_d = (act_q == 3'(ACT_CMP)) ? S_OUT : S_GCD_K;
			S_GCD_K:  if (nm_q == '0) state_d = S_OUT;
				else if (ga_q[0] || gb_q[0]) state_d = S_GCD_A;
			S_GCD_A:  if (ga_q[0]) state_d = S_GCD_B;
			S_GCD_B:  if (gb_q == '0) state_d = S_GCD_SHL;
				else if (gb_q[0]) state_d = S_GCD_SUB;
			S_GCD_SUB: state_d = S_GCD_B;
			S_GCD_SHL: if (k_q == '0) state_d = S_DIV_Q;
			S_DIV_Q:  if (dv_done) state_d = S_DIV_R;
			S_DIV_R:  if (dv_done) state_d = S_PACK;
			S_PACK:   state_d = S_OUT;
			S_OUT:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		dv_start = 1'b0;
		dv_num   = nm_q;
		unique case (state_q)
			S_GCD_SHL: dv_start = (k_q == '0);
			S_DIV_Q:   begin
				dv_start = dv_done;
				dv_num   = dm_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_xfer) ovalid_q <= 1'b0;
			else if (state_q == S_OUT) ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_xfer) begin
				act_q    <= in_ch.data.action;
				anm_q    <= i_an;
				adm_q    <= i_ad;
				bnm_q    <= i_bn;
				bdm_q    <= i_bd;
				an_q     <= s_an && (i_an != '0);
				bn_q     <= s_bn && (i_bn != '0);
				rnum_q   <= '0;
				rden_q   <= (WIDTH-1)'(1);
				order_q  <= ORD_LESS;
				status_q <= e_zero ? ST_ZERO : (e_sign ? ST_SIGN : ST_OK);
				nm_q     <= W2'(i_an);
				dm_q     <= W2'(i_ad);
				nneg_q   <= s_an;
				dneg_q   <= s_ad;
			end
			S_MUL1: p1_q <= prod;
			S_MUL2: p2_q <= prod;
			S_MUL3: p3_q <= prod;
			S_COMB: begin
				k_q <= '0;
				if (act_q == 3'(ACT_CMP)) begin
					if (an_q != bn_q) order_q <= an_q ? ORD_LESS : ORD_GREAT;
					else if (p1_q == p2_q) order_q <= ORD_EQUAL;
					else if ((p1_q > p2_q) ^ an_q) order_q <= ORD_GREAT;
					else order_q <= ORD_LESS;
					ga_q <= nm_q;
					gb_q <= dm_q;
				end else begin
					logic [W2-1:0] n_v, d_v;
					logic          nn_v, dn_v;
					n_v  = nm_q;
					d_v  = dm_q;
					nn_v = nneg_q;
					dn_v = dneg_q;
					unique case (act_q)
						3'(ACT_ADD), 3'(ACT_SUB): begin
							d_v  = p3_q;
							dn_v = 1'b0;
							if (an_q == s2) begin
								n_v  = t_sum;
								nn_v = an_q;
							end else if (t_ge) begin
								n_v  = t_d12;
								nn_v = an_q;
							end else begin
								n_v  = t_d21;
								nn_v = s2;
							end
						end
						3'(ACT_MUL): begin
							n_v  = p1_q;
							d_v  = p3_q;
							nn_v = an_q ^ bn_q;
							dn_v = 1'b0;
						end
						3'(ACT_DIV): begin
							n_v  = p1_q;
							d_v  = p2_q;
							nn_v = an_q;
							dn_v = bn_q;
						end
						default: ;
					endcase
					nm_q   <= n_v;
					dm_q   <= d_v;
					nneg_q <= nn_v;
					dneg_q <= dn_v;
					ga_q   <= n_v;
					gb_q   <= d_v;
				end
			end
			S_GCD_K: if (!(ga_q[0] || gb_q[0])) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				k_q  <= k_q + 1'b1;
			end
			S_GCD_A: if (!ga_q[0]) ga_q <= ga_q >> 1;
			S_GCD_B: if (gb_q != '0 && !gb_q[0]) gb_q <= gb_q >> 1;
			S_GCD_SUB: begin
				ga_q <= g_lo;
				gb_q <= g_hi - g_lo;
			end
			S_GCD_SHL: if (k_q != '0) begin
				ga_q <= ga_q << 1;
				k_q  <= k_q - 1'b1;
			end
			S_DIV_Q: if (dv_done) q_q <= dv_quo;
			S_DIV_R: ;
			S_PACK: begin
				if (ovf) begin
					status_q <= ST_OVFL;
				end else begin
					rnum_q <= neg ? -q_q[WIDTH-1:0] : q_q[WIDTH-1:0];
					rden_q <= dv_quo[WIDTH-2:0];
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.data.res_num = rnum_q;
	assign out_ch.data.res_den = rden_q;
	assign out_ch.data.order   = order_q;
	assign out_ch.data.status  = status_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ch.ready)
		else $error("input accepted while busy");
	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && status_q != ST_OK) |-> (rnum_q == '0 && rden_q == (WIDTH-1)'(1)))
		else $error("error result carries a value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ch.ready) |=> (ovalid_q && $stable(rnum_q) && $stable(status_q)))
		else $error("stalled result changed");
`endif
endmodule

/* design/rau_div.sv */
// ----------------------------------------------------------------------------
// rau_div: restoring divider
// Unsigned N-bit quotient, one bit per cycle; remainder discarded.
// ----------------------------------------------------------------------------
module rau_div #(
	parameter int unsigned N = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] num,
	input  logic [N-1:0] den,
	output logic         done,
	output logic [N-1:0] quo
);
	localparam int unsigned CW = $clog2(N + 1);

	logic [N-1:0]  n_q, d_q, q_q;
	logic [N:0]    r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [N:0]    r_sh;
	logic [N:0]    r_diff;

	assign r_sh   = {r_q[N-1:0], n_q[N-1]};
	assign r_diff = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			q_q <= '0;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[N-2:0], 1'b0};
			if (!r_diff[N]) begin
				r_q <= r_diff;
				q_q <= {q_q[N-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[N-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
